// ===== hw/rtl/ascon_pkg.sv =====
// ----------------------------------------------------------------------------
// Ascon-AEAD128 engine package
// Shared state type, permutation constants and item codes.
// ----------------------------------------------------------------------------
package ascon_pkg;

    // Five 64-bit sponge words, word 0 at index 0.
    typedef logic [4:0][63:0] state_t;

    // Round counts of the permutation.
    localparam int INIT_FINAL_ROUNDS = 12;
    localparam int BLOCK_ROUNDS      = 8;

    // The round constant index runs up to the last round of twelve.
    localparam logic [3:0] RC_LAST    = 4'(INIT_FINAL_ROUNDS - 1);
    localparam logic [3:0] RC_BASE_12 = 4'(INIT_FINAL_ROUNDS - INIT_FINAL_ROUNDS);
    localparam logic [3:0] RC_BASE_8  = 4'(INIT_FINAL_ROUNDS - BLOCK_ROUNDS);

    // Initial value word and domain separation bit.
    localparam logic [63:0] IV_WORD  = 64'h0000_1000_808C_0001;
    localparam logic [63:0] DSEP_BIT = 64'h8000_0000_0000_0000;

    // Block geometry.
    localparam int             BLOCK_BYTES = 16;
    localparam logic [4:0]     FULL_COUNT  = 5'(BLOCK_BYTES);
    localparam logic [7:0]     PAD_BYTE    = 8'h01;

    // Request kinds.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ASSOC  = 2'd1;
    localparam logic [1:0] OP_MSG    = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Sponge phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_AD   = 3'd1;
    localparam logic [2:0] PH_MSG  = 3'd2;
    localparam logic [2:0] PH_FIN  = 3'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_LOW      = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH     = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

    // Round constant for round index 0 to 11.
    function automatic logic [7:0] round_const(input logic [3:0] idx);
        logic [7:0] rc;
        unique case (idx)
            4'd0:    rc = 8'hf0;
            4'd1:    rc = 8'he1;
            4'd2:    rc = 8'hd2;
            4'd3:    rc = 8'hc3;
            4'd4:    rc = 8'hb4;
            4'd5:    rc = 8'ha5;
            4'd6:    rc = 8'h96;
            4'd7:    rc = 8'h87;
            4'd8:    rc = 8'h78;
            4'd9:    rc = 8'h69;
            4'd10:   rc = 8'h5a;
            4'd11:   rc = 8'h4b;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage

// ===== hw/rtl/ascon_round.sv =====
// ----------------------------------------------------------------------------
// Ascon permutation round
// One round of the permutation: constant addition, S-box layer and linear
// diffusion layer. The sequencer applies it once per cycle.
// ----------------------------------------------------------------------------
module ascon_round
    import ascon_pkg::*;
(
    input  state_t     state_in,
    input  logic [3:0] rc_idx,
    output state_t     state_out
);

    state_t a;
    state_t b;
    state_t t;

    // Constant addition and S-box layer, bitsliced over the five words.
    always_comb
    begin
        a    = state_in;
        a[2] = a[2] ^ {56'h0, round_const(rc_idx)};
        a[0] = a[0] ^ a[4];
        a[4] = a[4] ^ a[3];
        a[2] = a[2] ^ a[1];
        for (int i = 0; i < 5; i++)
        begin
            t[i] = ~a[i] & a[(i + 1) % 5];
        end
        for (int i = 0; i < 5; i++)
        begin
            b[i] = a[i] ^ t[(i + 1) % 5];
        end
        b[1] = b[1] ^ b[0];
        b[0] = b[0] ^ b[4];
        b[3] = b[3] ^ b[2];
        b[2] = ~b[2];
    end

    // Linear diffusion layer: each word mixes with two rotations of itself.
    assign state_out[0] = b[0] ^ {b[0][18:0], b[0][63:19]} ^ {b[0][27:0], b[0][63:28]};
    assign state_out[1] = b[1] ^ {b[1][60:0], b[1][63:61]} ^ {b[1][38:0], b[1][63:39]};
    assign state_out[2] = b[2] ^ {b[2][0],    b[2][63:1]}  ^ {b[2][5:0],  b[2][63:6]};
    assign state_out[3] = b[3] ^ {b[3][9:0],  b[3][63:10]} ^ {b[3][16:0], b[3][63:17]};
    assign state_out[4] = b[4] ^ {b[4][6:0],  b[4][63:7]}  ^ {b[4][40:0], b[4][63:41]};

endmodule

// ===== hw/rtl/ascon_aead128_engine.sv =====
// ----------------------------------------------------------------------------
// Ascon-AEAD128 engine
// Streaming authenticated encryption and decryption over a 320-bit sponge.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group: s_tuser carries the kind (start, associated
// data, message block, finish) and s_tdata the block and its byte count. Every
// request yields exactly one result on the m_ group; m_tuser is set when the
// request came out of sequence and was ignored. The user must write key and
// direction via the cfg_ port only while the engine is idle (not enforced).
// A single round unit is applied once per cycle under a small sequencer.
// A start or finish request runs 12 rounds and then the post step; an
// associated-data block, unless an empty first one, runs 8 rounds and the
// post step; a full message block runs its text step and then 8 rounds and
// the post step. A request that runs no permutation goes to its result
// directly or after the text step alone. A first message block that must
// close open associated data runs 8 rounds and the post step before its text.
// s_tready is high only while the sequencer is idle. The result register
// holds a finished result while the receiver stalls, and the next request is
// accepted meanwhile; that request's result waits in the sequencer until the
// result register frees. Reset clears the sponge, the phase and the key and
// mode registers, and leaves no result pending.
// ----------------------------------------------------------------------------
module ascon_aead128_engine
    import ascon_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [63:0]  cfg_data,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // data_lo[63:0], data_hi[127:64], byte_count[132:128]
    input  logic [1:0]   s_tuser,   // op[1:0]
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // out_lo[63:0], out_hi[127:64], out_count[132:128],
                                    // tag_ok[133]
    output logic         m_tuser    // status[0]
);

    // Sequencer codes.
    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_RUN  = 3'd1;
    localparam logic [2:0] SQ_POST = 3'd2;
    localparam logic [2:0] SQ_MSG  = 3'd3;
    localparam logic [2:0] SQ_DONE = 3'd4;

    // Actions to apply once the running permutation ends.
    typedef struct packed {
        logic key;
        logic dsep;
        logic msg;
        logic tag;
    } post_t;

    logic [2:0]   sq_reg, sq_next;
    logic [2:0]   phase_reg, phase_next;
    logic         saw_reg, saw_next;
    logic [3:0]   rc_reg, rc_next;
    post_t        post_reg, post_next;
    state_t       sponge_reg, sponge_next;
    state_t       round_out;

    logic [63:0]  key_low_reg;
    logic [63:0]  key_high_reg;
    logic         dec_reg;

    // Latched request payload.
    logic [63:0]  din_lo_reg, din_lo_next;
    logic [63:0]  din_hi_reg, din_hi_next;
    logic [4:0]   n_reg, n_next;

    // Pending result.
    logic [63:0]  res_lo_reg, res_lo_next;
    logic [63:0]  res_hi_reg, res_hi_next;
    logic [4:0]   res_cnt_reg, res_cnt_next;
    logic         res_tag_reg, res_tag_next;
    logic         res_st_reg, res_st_next;

    // Result register.
    logic         m_valid_reg, m_valid_next;
    logic [63:0]  m_lo_reg;
    logic [63:0]  m_hi_reg;
    logic [4:0]   m_cnt_reg;
    logic         m_tag_ok_reg;
    logic         m_status_reg;
    logic         m_load;

    logic         s_fire;
    logic [1:0]   in_op;
    logic [4:0]   in_cnt_raw;
    logic [4:0]   in_cnt;
    logic [127:0] in_data;
    logic [127:0] in_mask;
    logic [127:0] in_pad;
    logic [127:0] msg_mask;
    logic [127:0] msg_pad;
    logic [127:0] msg_data;
    logic [127:0] msg_rate;
    logic [127:0] msg_xor;
    logic [63:0]  fin_w3;
    logic [63:0]  fin_w4;

    // Byte mask with bytes below the count set.
    function automatic logic [127:0] byte_mask(input logic [4:0] cnt);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            m[8*i +: 8] = (5'(i) < cnt) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // Padding byte at position count; nothing for a full block.
    function automatic logic [127:0] pad_vec(input logic [4:0] cnt);
        logic [127:0] p;
        p = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            p[8*i +: 8] = (5'(i) == cnt) ? PAD_BYTE : 8'h00;
        end
        return p;
    endfunction

    // Shared round unit.
    ascon_round u_round (
        .state_in  (sponge_reg),
        .rc_idx    (rc_reg),
        .state_out (round_out)
    );

    // Request decode with the count clamped to a full block.
    assign s_tready   = (sq_reg == SQ_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign in_op      = s_tuser;
    assign in_cnt_raw = s_tdata[132:128];
    assign in_cnt     = (in_cnt_raw > FULL_COUNT) ? FULL_COUNT : in_cnt_raw;
    assign in_data    = s_tdata[127:0];
    assign in_mask    = byte_mask(in_cnt);
    assign in_pad     = pad_vec(in_cnt);

    // Text step operands from the latched request.
    assign msg_mask = byte_mask(n_reg);
    assign msg_pad  = pad_vec(n_reg);
    assign msg_data = {din_hi_reg, din_lo_reg} & msg_mask;
    assign msg_rate = {sponge_reg[1], sponge_reg[0]};
    assign msg_xor  = msg_rate ^ msg_data;

    // Key and domain-bit addition after a permutation, as the post flags select.
    assign fin_w3 = sponge_reg[3] ^ (post_reg.key ? key_low_reg  : 64'h0);
    assign fin_w4 = sponge_reg[4] ^ (post_reg.key ? key_high_reg : 64'h0)
                    ^ (post_reg.dsep ? DSEP_BIT : 64'h0);

    assign m_load = (sq_reg == SQ_DONE) && (!m_valid_reg || m_tready);

    // Sequencer.
    always_comb
    begin
        sq_next      = sq_reg;
        phase_next   = phase_reg;
        saw_next     = saw_reg;
        rc_next      = rc_reg;
        post_next    = post_reg;
        sponge_next  = sponge_reg;
        din_lo_next  = din_lo_reg;
        din_hi_next  = din_hi_reg;
        n_next       = n_reg;
        res_lo_next  = res_lo_reg;
        res_hi_next  = res_hi_reg;
        res_cnt_next = res_cnt_reg;
        res_tag_next = res_tag_reg;
        res_st_next  = res_st_reg;

        unique case (sq_reg)
            SQ_IDLE:
            begin
                if (s_fire)
                begin
                    din_lo_next  = s_tdata[63:0];
                    din_hi_next  = s_tdata[127:64];
                    n_next       = in_cnt;
                    res_lo_next  = '0;
                    res_hi_next  = '0;
                    res_cnt_next = '0;
                    res_tag_next = 1'b0;
                    res_st_next  = 1'b0;
                    post_next    = '0;
                    sq_next      = SQ_DONE;
                    unique case (in_op)
                        OP_START:
                        begin
                            sponge_next   = {s_tdata[127:64], s_tdata[63:0], key_high_reg,
                                             key_low_reg, IV_WORD};
                            rc_next       = RC_BASE_12;
                            post_next.key = 1'b1;
                            saw_next      = 1'b0;
                            phase_next    = PH_AD;
                            sq_next       = SQ_RUN;
                        end
                        OP_ASSOC:
                        begin
                            if (phase_reg != PH_AD)
                            begin
                                res_st_next = 1'b1;
                            end
                            else if (in_cnt == FULL_COUNT)
                            begin
                                {sponge_next[1], sponge_next[0]} =
                                    {sponge_reg[1], sponge_reg[0]} ^ in_data;
                                rc_next  = RC_BASE_8;
                                saw_next = 1'b1;
                                sq_next  = SQ_RUN;
                            end
                            else
                            begin
                                // Final block; an empty first block absorbs nothing.
                                phase_next = PH_MSG;
                                if ((in_cnt != 5'd0) || saw_reg)
                                begin
                                    {sponge_next[1], sponge_next[0]} =
                                        {sponge_reg[1], sponge_reg[0]}
                                        ^ (in_data & in_mask) ^ in_pad;
                                    rc_next        = RC_BASE_8;
                                    post_next.dsep = 1'b1;
                                    sq_next        = SQ_RUN;
                                end
                                else
                                begin
                                    sponge_next[4] = sponge_reg[4] ^ DSEP_BIT;
                                end
                            end
                        end
                        OP_MSG:
                        begin
                            priority if (phase_reg == PH_MSG)
                            begin
                                sq_next = SQ_MSG;
                            end
                            else if (phase_reg == PH_AD && saw_reg)
                            begin
                                // Close the open associated data with a bare pad block.
                                sponge_next[0] = sponge_reg[0] ^ {56'h0, PAD_BYTE};
                                rc_next        = RC_BASE_8;
                                post_next.dsep = 1'b1;
                                post_next.msg  = 1'b1;
                                phase_next     = PH_MSG;
                                sq_next        = SQ_RUN;
                            end
                            else if (phase_reg == PH_AD)
                            begin
                                sponge_next[4] = sponge_reg[4] ^ DSEP_BIT;
                                phase_next     = PH_MSG;
                                sq_next        = SQ_MSG;
                            end
                            else
                            begin
                                res_st_next = 1'b1;
                            end
                        end
                        OP_FINISH:
                        begin
                            if (phase_reg != PH_FIN)
                            begin
                                res_st_next = 1'b1;
                            end
                            else
                            begin
                                sponge_next[2] = sponge_reg[2] ^ key_low_reg;
                                sponge_next[3] = sponge_reg[3] ^ key_high_reg;
                                rc_next        = RC_BASE_12;
                                post_next.key  = 1'b1;
                                post_next.tag  = 1'b1;
                                saw_next       = 1'b0;
                                phase_next     = PH_IDLE;
                                sq_next        = SQ_RUN;
                            end
                        end
                        default:
                        begin
                            res_st_next = 1'b1;
                        end
                    endcase
                end
            end
            SQ_RUN:
            begin
                sponge_next = round_out;
                if (rc_reg == RC_LAST)
                begin
                    rc_next = '0;
                    sq_next = SQ_POST;
                end
                else
                begin
                    rc_next = rc_reg + 4'd1;
                end
            end
            SQ_POST:
            begin
                sponge_next[3] = fin_w3;
                sponge_next[4] = fin_w4;
                if (post_reg.tag)
                begin
                    res_lo_next  = fin_w3;
                    res_hi_next  = fin_w4;
                    res_cnt_next = FULL_COUNT;
                    res_tag_next = dec_reg && (fin_w3 == din_lo_reg)
                                   && (fin_w4 == din_hi_reg);
                end
                post_next = '0;
                sq_next   = post_reg.msg ? SQ_MSG : SQ_DONE;
            end
            SQ_MSG:
            begin
                // Encrypt keeps the XOR; decrypt takes the ciphertext into the rate.
                {res_hi_next, res_lo_next} = msg_xor & msg_mask;
                res_cnt_next = n_reg;
                if (dec_reg)
                begin
                    {sponge_next[1], sponge_next[0]} =
                        (msg_data | (msg_rate & ~msg_mask)) ^ msg_pad;
                end
                else
                begin
                    {sponge_next[1], sponge_next[0]} = msg_xor ^ msg_pad;
                end
                if (n_reg == FULL_COUNT)
                begin
                    rc_next = RC_BASE_8;
                    sq_next = SQ_RUN;
                end
                else
                begin
                    phase_next = PH_FIN;
                    sq_next    = SQ_DONE;
                end
            end
            SQ_DONE:
            begin
                if (m_load)
                begin
                    sq_next = SQ_IDLE;
                end
            end
            default:
            begin
                sq_next = SQ_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg      <= SQ_IDLE;
            phase_reg   <= PH_IDLE;
            saw_reg     <= 1'b0;
            rc_reg      <= '0;
            post_reg    <= '0;
            sponge_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            sq_reg      <= sq_next;
            phase_reg   <= phase_next;
            saw_reg     <= saw_next;
            rc_reg      <= rc_next;
            post_reg    <= post_next;
            sponge_reg  <= sponge_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            dec_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_KEY_LOW:      key_low_reg  <= cfg_data;
                REG_KEY_HIGH:     key_high_reg <= cfg_data;
                REG_DECRYPT_MODE: dec_reg      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Request payload and pending result.
    always_ff @(posedge clk)
    begin
        din_lo_reg  <= din_lo_next;
        din_hi_reg  <= din_hi_next;
        n_reg       <= n_next;
        res_lo_reg  <= res_lo_next;
        res_hi_reg  <= res_hi_next;
        res_cnt_reg <= res_cnt_next;
        res_tag_reg <= res_tag_next;
        res_st_reg  <= res_st_next;
    end

    // Result register valid flag.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            m_lo_reg     <= res_lo_reg;
            m_hi_reg     <= res_hi_reg;
            m_cnt_reg    <= res_cnt_reg;
            m_tag_ok_reg <= res_tag_reg;
            m_status_reg <= res_st_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_tag_ok_reg, m_cnt_reg, m_hi_reg, m_lo_reg};
    assign m_tuser  = m_status_reg;

    // An ignored request reports no data.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg) |->
            (m_lo_reg == 64'h0 && m_hi_reg == 64'h0 && m_cnt_reg == 5'd0 && !m_tag_ok_reg))
        else $error("ignored request carries result data");

    // A passing tag only comes with a full tag result.
    a_tag_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_tag_ok_reg) |-> (m_cnt_reg == FULL_COUNT && dec_reg))
        else $error("tag_ok set outside a decrypting finish");

    // The engine is busy in the cycle after it takes a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    // The round index never passes the last round while running.
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_reg == SQ_RUN) |-> (rc_reg <= RC_LAST))
        else $error("round index out of range");

    // Between sessions no associated data is marked.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> !saw_reg)
        else $error("associated data flag set while idle");

endmodule
